// ----- rtl/core/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared constants, types and the UTF-8 byte encoder of the transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

   localparam int UnitWidth     = 16;
   localparam int ByteWidth     = 8;
   localparam int MaxBytes      = 4;
   localparam int CountWidth    = $clog2(MaxBytes + 1);
   localparam int IndexWidth    = $clog2(MaxBytes);
   localparam int CodeWidth     = 21;
   localparam int SurrBits      = 10;

   localparam logic [UnitWidth-1:0] BomLittle  = 16'hFFFE;
   localparam logic [UnitWidth-1:0] SurrFirst  = 16'hD800;
   localparam logic [UnitWidth-1:0] SurrLow    = 16'hDC00;
   localparam logic [UnitWidth-1:0] SurrLast   = 16'hDFFF;
   localparam logic [CodeWidth-1:0] SuppBase   = 21'h10000;
   localparam logic [CodeWidth-1:0] Limit1Byte = 21'h80;
   localparam logic [CodeWidth-1:0] Limit2Byte = 21'h800;
   localparam logic [CodeWidth-1:0] Limit3Byte = 21'h10000;

   localparam logic [ByteWidth-1:0] Lead2 = 8'b1100_0000;
   localparam logic [ByteWidth-1:0] Lead3 = 8'b1110_0000;
   localparam logic [ByteWidth-1:0] Lead4 = 8'b1111_0000;
   localparam logic [ByteWidth-1:0] Cont  = 8'b1000_0000;

   // One decoded run: the bytes in output order and how many are valid.
   typedef struct packed {
      logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
      logic [CountWidth-1:0]              count;
   } run_type;

   function automatic run_type encode_utf8(input logic [CodeWidth-1:0] cp);
      run_type run;
      run = '0;
      if (cp < Limit1Byte) begin
         run.bytes[0] = {1'b0, cp[6:0]};
         run.count    = CountWidth'(1);
      end else if (cp < Limit2Byte) begin
         run.bytes[0] = Lead2 | {3'b000, cp[10:6]};
         run.bytes[1] = Cont | {2'b00, cp[5:0]};
         run.count    = CountWidth'(2);
      end else if (cp < Limit3Byte) begin
         run.bytes[0] = Lead3 | {4'b0000, cp[15:12]};
         run.bytes[1] = Cont | {2'b00, cp[11:6]};
         run.bytes[2] = Cont | {2'b00, cp[5:0]};
         run.count    = CountWidth'(3);
      end else begin
         run.bytes[0] = Lead4 | {5'b00000, cp[20:18]};
         run.bytes[1] = Cont | {2'b00, cp[17:12]};
         run.bytes[2] = Cont | {2'b00, cp[11:6]};
         run.bytes[3] = Cont | {2'b00, cp[5:0]};
         run.count    = CountWidth'(4);
      end
      return run;
   endfunction

endpackage

// ----- rtl/core/u16u8_decode.sv -----
// ----------------------------------------------------------------------------
// u16u8_decode
// String state and code unit decoder: byte order, surrogate pairing,
// string end, and the UTF-8 run for one registered code unit.
// ----------------------------------------------------------------------------
module u16u8_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [u16u8_pkg::UnitWidth-1:0]   unit_bytes,
   input  logic                              string_start,
   input  logic                              string_final,
   output u16u8_pkg::run_type                run
);
   import u16u8_pkg::*;

   logic                little_endian_ff, little_endian_in;
   logic                pending_ff, pending_in;
   logic [SurrBits-1:0] high_bits_ff, high_bits_in;
   logic                ended_ff, ended_in;

   logic [UnitWidth-1:0] cp;
   logic [CodeWidth-1:0] full;
   logic                 is_surr;
   logic                 is_low;

   always_comb begin
      cp      = little_endian_ff ? {unit_bytes[7:0], unit_bytes[15:8]} : unit_bytes;
      is_surr = (cp >= SurrFirst) && (cp <= SurrLast);
      is_low  = (cp >= SurrLow) && (cp <= SurrLast);
      full    = {1'b0, high_bits_ff, cp[SurrBits-1:0]} + SuppBase;

      little_endian_in = little_endian_ff;
      pending_in       = pending_ff;
      high_bits_in     = high_bits_ff;
      ended_in         = ended_ff;
      run              = '0;

      if (string_start) begin
         little_endian_in = (unit_bytes == BomLittle);
         pending_in       = 1'b0;
         high_bits_in     = '0;
         ended_in         = string_final;
      end else if (!ended_ff) begin
         if (pending_ff) begin
            // second half consumed unchecked; a non-low unit drops the pair
            pending_in   = 1'b0;
            high_bits_in = '0;
            if (is_low) begin
               run = encode_utf8(full);
            end
         end else if (unit_bytes == '0) begin
            ended_in = 1'b1;
         end else if (!is_surr) begin
            run = encode_utf8({5'b00000, cp});
         end else if (!is_low) begin
            pending_in   = 1'b1;
            high_bits_in = cp[SurrBits-1:0];
         end
         if (string_final) begin
            pending_in   = 1'b0;
            high_bits_in = '0;
            ended_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         little_endian_ff <= 1'b0;
         pending_ff       <= 1'b0;
         high_bits_ff     <= '0;
         ended_ff         <= 1'b0;
      end else if (advance) begin
         little_endian_ff <= little_endian_in;
         pending_ff       <= pending_in;
         high_bits_ff     <= high_bits_in;
         ended_ff         <= ended_in;
      end
   end

endmodule

// ----- rtl/core/u16u8_serializer.sv -----
// ----------------------------------------------------------------------------
// u16u8_serializer
// Result register: holds one decoded run and sends it one byte a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module u16u8_serializer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  u16u8_pkg::run_type                run,
   output logic                              can_load,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [u16u8_pkg::ByteWidth-1:0]   rsp_utf8_byte,
   output logic                              rsp_run_last
);
   import u16u8_pkg::*;

   logic [MaxBytes-1:0][ByteWidth-1:0] bytes_ff, bytes_in;
   logic [CountWidth-1:0]              count_ff, count_in;
   logic [IndexWidth-1:0]              index_ff, index_in;
   logic                               take;

   always_comb begin
      rsp_valid     = (count_ff != '0);
      rsp_utf8_byte = bytes_ff[index_ff];
      rsp_run_last  = ({1'b0, index_ff} == (count_ff - CountWidth'(1)));
      take          = rsp_valid && rsp_ready;
      can_load      = !rsp_valid || (take && rsp_run_last);

      bytes_in = bytes_ff;
      count_in = count_ff;
      index_in = index_ff;
      if (load) begin
         bytes_in = run.bytes;
         count_in = run.count;
         index_in = '0;
      end else if (take) begin
         // drop the run after its last byte, else advance
         if (rsp_run_last) begin
            count_in = '0;
         end else begin
            index_in = index_ff + IndexWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
      bytes_ff <= bytes_in;
   end

endmodule

// ----- rtl/core/utf16_to_utf8_transcoder_core.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// UTF-16 code unit stream in, UTF-8 byte stream out.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one UTF-16 code unit per transaction, first stream byte in
//   req_unit_bytes[15:8]. req_string_start marks the byte-order mark unit,
//   req_string_final the last unit of a string.
//   rsp_ carries one UTF-8 byte per transaction; rsp_run_last flags the
//   final byte produced by one code unit. A unit produces 0 to 4 bytes.
// Path: the first byte of a unit is offered once the unit has passed the
//   input register and been decoded into the result register; while the
//   result register is busy the unit waits in the input register.
// Flow: the bytes of a unit leave through the single byte-wide result
//   port, up to 3 for a BMP unit and 4 for a surrogate pair; the next unit
//   loads as the last byte is taken; units that produce nothing skip the port.
// Stall: while the receiver holds rsp_ready low the current run waits in
//   the result register, one more unit waits in the input register, and
//   req_ready falls once both are occupied.
// Reset: drops everything in flight; byte order returns to big-endian and
//   no surrogate is pending.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [u16u8_pkg::UnitWidth-1:0]   req_unit_bytes,
   input  logic                              req_string_start,
   input  logic                              req_string_final,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [u16u8_pkg::ByteWidth-1:0]   rsp_utf8_byte,
   output logic                              rsp_run_last
);
   import u16u8_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [UnitWidth-1:0] unit_ff, unit_in;
   logic                 start_ff, start_in;
   logic                 final_ff, final_in;
   logic                 can_load;
   logic                 advance;
   logic                 accept;
   run_type              run;

   always_comb begin
      advance   = in_valid_ff && can_load;
      req_ready = !in_valid_ff || can_load;
      accept    = req_valid && req_ready;

      in_valid_in = in_valid_ff;
      unit_in     = unit_ff;
      start_in    = start_ff;
      final_in    = final_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         unit_in     = req_unit_bytes;
         start_in    = req_string_start;
         final_in    = req_string_final;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      unit_ff  <= unit_in;
      start_ff <= start_in;
      final_ff <= final_in;
   end

   u16u8_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .unit_bytes   (unit_ff),
      .string_start (start_ff),
      .string_final (final_ff),
      .run          (run)
   );

   u16u8_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .load          (advance),
      .run           (run),
      .can_load      (can_load),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_utf8_byte (rsp_utf8_byte),
      .rsp_run_last  (rsp_run_last)
   );

   // A unit waiting for a busy result register must not be disturbed.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !can_load |=> in_valid_ff && $stable(unit_ff) && $stable(start_ff))
      else $error("input register changed while stalled");

   // A decoded run with bytes shows up on the result channel next cycle.
   a_run_shown: assert property (@(posedge clock) disable iff (reset)
      advance && (run.count != '0) |=> rsp_valid)
      else $error("loaded run not presented");

   // A four-byte run always opens with a four-byte lead.
   a_lead4: assert property (@(posedge clock) disable iff (reset)
      advance && (run.count == CountWidth'(4)) |-> (run.bytes[0][7:3] == 5'b11110))
      else $error("bad lead byte for supplementary character");

   // A start unit never produces bytes.
   a_bom_silent: assert property (@(posedge clock) disable iff (reset)
      advance && start_ff |-> (run.count == '0))
      else $error("byte-order mark produced output");

endmodule

// ----- tb/utf16_to_utf8_transcoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core_tb
// Drives UTF-16 code units into the transcoder and checks every UTF-8 byte
// against a cycle-free predictor of the decode: byte-order marks, string
// ends, surrogate pairing and drops. Directed corner cases come first, then
// random strings under several idle and stall patterns and back-pressure.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import u16u8_pkg::*;

   localparam logic [UnitWidth-1:0] BomBig     = 16'hFEFF;
   localparam logic [UnitWidth-1:0] Terminator = 16'h0000;
   localparam int                   StallLimit = 2000;

   typedef struct {
      logic [ByteWidth-1:0] utf8_byte;
      logic                 run_last;
   } utf8_byte_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [UnitWidth-1:0] req_unit_bytes;
   logic                 req_string_start;
   logic                 req_string_final;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [ByteWidth-1:0] rsp_utf8_byte;
   logic                 rsp_run_last;

   // decoder state mirrored from the block
   logic                little_endian;
   logic                high_held;
   logic [SurrBits-1:0] high_bits;
   logic                text_ended;

   utf8_byte_type utf8_expected[$];
   int         mismatches    = 0;
   int         decoded_units = 0;
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         rsp_hold_request = 0;
   int         quiet_cycles  = 0;

   utf16_to_utf8_transcoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_unit_bytes   (req_unit_bytes),
      .req_string_start (req_string_start),
      .req_string_final (req_string_final),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_utf8_byte    (rsp_utf8_byte),
      .rsp_run_last     (rsp_run_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void append_utf8(input logic [CodeWidth-1:0] cp);
      logic [ByteWidth-1:0] b[MaxBytes];
      int                   n;
      utf8_byte_type        item;
      if (cp < Limit1Byte) begin
         b[0] = {1'b0, cp[6:0]};
         n = 1;
      end else if (cp < Limit2Byte) begin
         b[0] = Lead2 | 8'(cp[10:6]);
         b[1] = Cont | 8'(cp[5:0]);
         n = 2;
      end else if (cp < Limit3Byte) begin
         b[0] = Lead3 | 8'(cp[15:12]);
         b[1] = Cont | 8'(cp[11:6]);
         b[2] = Cont | 8'(cp[5:0]);
         n = 3;
      end else begin
         b[0] = Lead4 | 8'(cp[20:18]);
         b[1] = Cont | 8'(cp[17:12]);
         b[2] = Cont | 8'(cp[11:6]);
         b[3] = Cont | 8'(cp[5:0]);
         n = 4;
      end
      for (int k = 0; k < n; k++) begin
         item.utf8_byte = b[k];
         item.run_last  = (k == n - 1);
         utf8_expected.push_back(item);
      end
   endfunction

   function automatic void transcode_unit(input logic [UnitWidth-1:0] unit,
                                          input logic is_start, input logic is_final);
      logic [UnitWidth-1:0] code;
      logic [CodeWidth-1:0] full;
      if (is_start) begin
         little_endian = (unit == BomLittle);
         high_held     = 1'b0;
         high_bits     = '0;
         text_ended    = is_final;
         decoded_units++;
         return;
      end
      if (text_ended) return;
      decoded_units++;
      code = little_endian ? {unit[7:0], unit[15:8]} : unit;
      if (high_held) begin
         // the unit after a high surrogate is consumed whatever it is
         high_held = 1'b0;
         if (code >= SurrLow && code <= SurrLast) begin
            full = {1'b0, high_bits, code[9:0]} + SuppBase;
            append_utf8(full);
         end
         high_bits = '0;
      end else if (unit == Terminator) begin
         text_ended = 1'b1;
      end else if (code < SurrFirst || code > SurrLast) begin
         append_utf8(CodeWidth'(code));
      end else if (code < SurrLow) begin
         high_held = 1'b1;
         high_bits = code[9:0];
      end
      if (is_final) begin
         high_held  = 1'b0;
         high_bits  = '0;
         text_ended = 1'b1;
      end
   endfunction

   task automatic send_unit(input logic [UnitWidth-1:0] unit,
                            input logic is_start, input logic is_final);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_unit_bytes   <= unit;
      req_string_start <= is_start;
      req_string_final <= is_final;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      transcode_unit(unit, is_start, is_final);
   endtask

   task automatic send_code(input logic [UnitWidth-1:0] code, input logic le,
                            input logic is_final);
      send_unit(le ? {code[7:0], code[15:8]} : code, 1'b0, is_final);
   endtask

   // one character of random class, possibly a pair or a broken pair
   task automatic send_random_char(input logic le, input logic is_final);
      int kind;
      kind = $urandom_range(9);
      case (kind)
         0, 1, 2: send_code(16'($urandom_range(1, 16'h007F)), le, is_final);
         3:       send_code(16'($urandom_range(16'h0080, 16'h07FF)), le, is_final);
         4:       send_code(16'($urandom_range(16'h0800, 16'hD7FF)), le, is_final);
         5:       send_code(16'($urandom_range(16'hE000, 16'hFFFF)), le, is_final);
         6, 7: begin
            send_code(16'($urandom_range(SurrFirst, SurrLow - 1)), le, 1'b0);
            send_code(16'($urandom_range(SurrLow, SurrLast)), le, is_final);
         end
         8: begin
            if ($urandom_range(1)) begin
               send_code(16'($urandom_range(SurrLow, SurrLast)), le, is_final);
            end else begin
               send_code(16'($urandom_range(SurrFirst, SurrLow - 1)), le, 1'b0);
               send_code(16'($urandom_range(0, SurrFirst - 1)), le, is_final);
            end
         end
         default: send_code(16'($urandom), le, is_final);
      endcase
   endtask

   task automatic run_random_strings(input int unit_target);
      int                   base;
      int                   len;
      int                   ending;
      logic                 le;
      logic [UnitWidth-1:0] mark;
      base = decoded_units;
      while (decoded_units - base < unit_target) begin
         if ($urandom_range(99) < 12) begin
            // noise: any unit with any flags
            send_unit(16'($urandom), $urandom_range(4) == 0, $urandom_range(4) == 0);
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4: mark = BomLittle;
               9:             mark = 16'($urandom);
               default:       mark = BomBig;
            endcase
            le = (mark == BomLittle);
            send_unit(mark, 1'b1, 1'b0);
            len    = $urandom_range(1, 10);
            ending = $urandom_range(2);
            for (int i = 0; i < len; i++)
               send_random_char(le, (ending == 1) && (i == len - 1));
            if (ending == 0) begin
               send_unit(Terminator, 1'b0, $urandom_range(1));
               if ($urandom_range(3) == 0) send_code(16'($urandom), le, 1'b0);
            end
         end
      end
   endtask

   task automatic test_directed_cases();
      // before any mark the order is big-endian
      send_unit(16'h0041, 1'b0, 1'b0);
      send_unit(16'h0001, 1'b0, 1'b0);
      send_unit(16'h007F, 1'b0, 1'b0);
      send_unit(16'h0080, 1'b0, 1'b0);
      send_unit(16'h07FF, 1'b0, 1'b0);
      send_unit(16'h0800, 1'b0, 1'b0);
      send_unit(16'hD7FF, 1'b0, 1'b0);
      send_unit(16'hE000, 1'b0, 1'b0);
      send_unit(16'hFFFF, 1'b0, 1'b0);
      send_unit(SurrFirst, 1'b0, 1'b0);
      send_unit(SurrLow, 1'b0, 1'b0);
      send_unit(16'(SurrLow - 1), 1'b0, 1'b0);
      send_unit(SurrLast, 1'b0, 1'b0);
      send_unit(SurrLow, 1'b0, 1'b0);       // lone low surrogate
      send_unit(16'hD955, 1'b0, 1'b0);
      send_unit(16'h0041, 1'b0, 1'b0);      // drops the pair
      send_unit(16'hDA00, 1'b0, 1'b0);
      send_unit(Terminator, 1'b0, 1'b0);    // swallowed, string goes on
      send_unit(16'h0042, 1'b0, 1'b0);
      send_unit(Terminator, 1'b0, 1'b0);
      send_unit(16'h0043, 1'b0, 1'b0);      // after the end: ignored
      send_unit(BomLittle, 1'b1, 1'b0);
      send_unit(16'h4100, 1'b0, 1'b0);
      send_unit(16'h3DD8, 1'b0, 1'b0);
      send_unit(16'h00DE, 1'b0, 1'b0);
      send_unit(16'h00D8, 1'b0, 1'b1);      // high surrogate on the last unit
      send_unit(16'h4100, 1'b0, 1'b0);
      send_unit(BomBig, 1'b1, 1'b1);        // mark that is also the last unit
      send_unit(16'h0041, 1'b0, 1'b0);
      send_unit(16'h1234, 1'b1, 1'b0);      // unknown mark: big-endian
      send_unit(16'hFFFF, 1'b0, 1'b1);
   endtask

   task automatic test_streaming_no_idle();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_strings(100);
   endtask

   task automatic test_sender_idle();
      send_idle_pct = 77;
      rsp_stall_pct = 0;
      run_random_strings(90);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct = 0;
      rsp_stall_pct = 77;
      run_random_strings(90);
   endtask

   task automatic test_both_idle();
      send_idle_pct = 31;
      rsp_stall_pct = 31;
      run_random_strings(90);
   endtask

   // hold the receiver off and keep offering three-byte characters
   task automatic test_receiver_hold_off();
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      rsp_hold_request = 300;
      send_unit(BomBig, 1'b1, 1'b0);
      for (int i = 0; i < 24; i++)
         send_code(16'($urandom_range(16'h0800, 16'hD7FF)), 1'b0, 1'b0);
   endtask

   // stop sending until every byte in flight has come out, then resume
   task automatic test_sender_pause();
      send_idle_pct = 0;
      rsp_stall_pct = 50;
      send_unit(BomLittle, 1'b1, 1'b0);
      for (int i = 0; i < 8; i++) send_random_char(1'b1, 1'b0);
      req_valid <= 1'b0;
      while (utf8_expected.size() != 0) @(posedge clock);
      for (int i = 0; i < 8; i++) send_random_char(1'b1, i == 7);
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_unit_bytes   <= '0;
      req_string_start <= 1'b0;
      req_string_final <= 1'b0;
      little_endian = 1'b0;
      high_held     = 1'b0;
      high_bits     = '0;
      text_ended    = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_streaming_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_receiver_hold_off();
      test_sender_pause();

      req_valid <= 1'b0;
      rsp_stall_pct = 0;
      while (utf8_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // receiver: random stalls, plus a long hold-off when one is requested
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      utf8_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (utf8_expected.size() == 0) begin
            $error("unexpected rsp transaction: utf8_byte %02h run_last %0b",
                   rsp_utf8_byte, rsp_run_last);
            mismatches++;
         end else begin
            want = utf8_expected.pop_front();
            if (rsp_utf8_byte !== want.utf8_byte) begin
               $error("utf8_byte: expected %02h, actual %02h", want.utf8_byte, rsp_utf8_byte);
               mismatches++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %0b, actual %0b", want.run_last, rsp_run_last);
               mismatches++;
            end
         end
      end
   end

   // end the run if no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
